>>> sv/wic_pkg.sv
`timescale 1ns / 1ps
package wic_pkg;

    localparam int MAX_SLOTS_DEF    = 64;
    localparam int PRICE_BITS_DEF   = 40;
    localparam int WEIGHT_FRAC_DEF  = 16;

    localparam int SLOT_W       = 6;
    localparam int PRICE_IN_W   = 40;
    localparam int OI_W         = 32;
    localparam int VOL_W        = 32;
    localparam int TURN_W       = 48;
    localparam int TS_W         = 48;
    localparam int DATE_W       = 27;
    localparam int WGT_IN_W     = 24;
    localparam int SCALE_W      = 24;
    localparam int SCALE_FRAC   = 16;
    localparam int TOFF_W       = 16;
    localparam int COUNT_W      = 7;
    localparam int MODE_W       = 2;
    localparam int SUMV_W       = 38;
    localparam int SUMT_W       = 54;
    localparam int OUT_VAL_W    = 40;

    localparam int IN_TDATA_W   = 264;
    localparam int OUT_TDATA_W  = 368;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 24;

    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC;

    // Drain step at which the product sum is complete.
    localparam int PIPE_LAST = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MODE,
        CFG_SCALE,
        CFG_ANY,
        CFG_TSLOT,
        CFG_TOFF,
        CFG_COUNT
    } t_cfg_idx;

    typedef enum logic [MODE_W-1:0] {
        WM_FIXED,
        WM_INTEREST,
        WM_VOLUME,
        WM_BAD
    } t_weight_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_DIV,
        S_DONE
    } t_wic_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_DIV
    } t_div_state;

    typedef struct packed {
        logic              shift;
        logic              we_quote;
        logic              we_weight;
        logic [SLOT_W-1:0] slot;
    } t_cell_ctl;

endpackage

>>> sv/wic_cell.sv
`timescale 1ns / 1ps
module wic_cell #(
    parameter int DATA_W   = 235,
    parameter int WGT_W    = 24,
    parameter int WFB      = 16,
    parameter int CELL_IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wic_pkg::t_cell_ctl i_ctl,
    input  logic [WGT_W-1:0]   i_wr_weight,
    input  logic [DATA_W-1:0]  i_wr_data,
    input  logic               i_nbr_valid,
    input  logic [WGT_W-1:0]   i_nbr_weight,
    input  logic [DATA_W-1:0]  i_nbr_data,
    output logic               o_valid,
    output logic [WGT_W-1:0]   o_weight,
    output logic [DATA_W-1:0]  o_data
);
    import wic_pkg::*;

    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << WFB;

    logic              r_valid;
    logic [WGT_W-1:0]  r_weight;
    logic [DATA_W-1:0] r_data;
    logic              w_sel;

    assign w_sel = (32'(i_ctl.slot) == 32'(CELL_IDX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_weight <= WGT_ONE;
        end else if (i_ctl.shift) begin
            r_valid  <= i_nbr_valid;
            r_weight <= i_nbr_weight;
        end else begin
            if (i_ctl.we_quote && w_sel) begin
                r_valid <= 1'b1;
            end
            if (i_ctl.we_weight && w_sel) begin
                r_weight <= i_wr_weight;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_data <= i_nbr_data;
        end else if (i_ctl.we_quote && w_sel) begin
            r_data <= i_wr_data;
        end
    end

    assign o_valid  = r_valid;
    assign o_weight = r_weight;
    assign o_data   = r_data;

endmodule

>>> sv/wic_div.sv
`timescale 1ns / 1ps
module wic_div #(
    parameter int NUM_W  = 137,
    parameter int BASE_W = 39,
    parameter int WSUM_W = 31,
    parameter int PW     = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [NUM_W-1:0]            i_num,
    input  logic [wic_pkg::SCALE_W-1:0] i_scale,
    input  logic [BASE_W-1:0]           i_base,
    input  logic [WSUM_W-1:0]           i_wsum,
    output logic                        o_done,
    output logic [PW-1:0]               o_quot
);
    import wic_pkg::*;

    localparam int SNUM_W    = NUM_W + SCALE_W;
    localparam int DEN_W     = BASE_W + WSUM_W;
    localparam int DSH_W     = DEN_W + SCALE_FRAC + PW;
    localparam int WORK_W    = (SNUM_W > DSH_W) ? SNUM_W : DSH_W;
    localparam int MUL_STEPS = (WSUM_W > SCALE_W) ? WSUM_W : SCALE_W;
    localparam int LAST      = (MUL_STEPS > PW + 1) ? MUL_STEPS : PW + 1;
    localparam int STEP_W    = $clog2(LAST + 1);

    t_div_state        r_state;
    t_div_state        n_state;
    logic [STEP_W-1:0] r_step;
    logic [SNUM_W-1:0] r_acc;
    logic [SNUM_W-1:0] r_mcand;
    logic [SCALE_W-1:0] r_mult;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_dcand;
    logic [WSUM_W-1:0] r_dmult;
    logic [WORK_W-1:0] r_rem;
    logic [WORK_W-1:0] r_dsh;
    logic              r_sat;
    logic [PW-1:0]     r_q;
    logic [SNUM_W-1:0] n_acc;
    logic [DEN_W-1:0]  n_den;
    logic              w_ge;
    logic              w_mul_last;
    logic              w_div_last;

    assign n_acc      = r_mult[0] ? r_acc + r_mcand : r_acc;
    assign n_den      = r_dmult[0] ? r_den + r_dcand : r_den;
    assign w_ge       = (r_rem >= r_dsh);
    assign w_mul_last = (r_step == STEP_W'(MUL_STEPS - 1));
    assign w_div_last = (r_step == STEP_W'(PW));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) n_state = D_MUL;
            end
            D_MUL: begin
                if (w_mul_last) n_state = D_DIV;
            end
            D_DIV: begin
                if (w_div_last) n_state = D_IDLE;
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_step  <= '0;
                        r_acc   <= '0;
                        r_mcand <= SNUM_W'(i_num);
                        r_mult  <= i_scale;
                        r_den   <= '0;
                        r_dcand <= DEN_W'(i_base);
                        r_dmult <= i_wsum;
                    end
                end
                D_MUL: begin
                    r_acc   <= n_acc;
                    r_mcand <= r_mcand << 1;
                    r_mult  <= r_mult >> 1;
                    r_den   <= n_den;
                    r_dcand <= r_dcand << 1;
                    r_dmult <= r_dmult >> 1;
                    r_step  <= r_step + 1'b1;
                    if (w_mul_last) begin
                        r_rem  <= WORK_W'(n_acc);
                        r_dsh  <= WORK_W'(n_den) << (SCALE_FRAC + PW);
                        r_step <= '0;
                        r_sat  <= 1'b0;
                        r_q    <= '0;
                    end
                end
                D_DIV: begin
                    if (w_ge) r_rem <= r_rem - r_dsh;
                    if (r_step == '0) begin
                        r_sat <= w_ge;
                    end else begin
                        r_q <= {r_q[PW-2:0], w_ge};
                    end
                    r_dsh  <= r_dsh >> 1;
                    r_step <= r_step + 1'b1;
                    if (w_div_last) begin
                        o_done <= 1'b1;
                        o_quot <= r_sat ? {PW{1'b1}} : {r_q[PW-2:0], w_ge};
                    end
                end
                default: begin
                    r_step <= '0;
                end
            endcase
        end
    end

endmodule

>>> sv/weighted_index_calculator_core.sv
`timescale 1ns / 1ps
// Weight loads and quotes that do not trigger are accepted while the core stays idle.
// A triggering quote walks the cell ring and then drains the product pipeline; if all
// walked slots were valid and no divide error is flagged, the shift-add scaler and then
// the restoring divider run; otherwise no result or an error result is given.
// Only one item is in work at a time; a finished result waits in the output register.
// Reset clears all valid bits, sets every weight to 1.0 and restores the register defaults.
module weighted_index_calculator_core #(
    parameter int MAX_SLOTS        = wic_pkg::MAX_SLOTS_DEF,
    parameter int PRICE_BITS       = wic_pkg::PRICE_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = wic_pkg::WEIGHT_FRAC_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // slot, price, open_interest, volume, turnover, timestamp, trading_date, weight
    input  logic [wic_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // index_value, open_value, high_value, low_value, sum_volume, sum_interest,
    // sum_turnover, index_time, index_date
    output logic [wic_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // divide_error
    output logic [0:0]                      m_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [wic_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [wic_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import wic_pkg::*;

    localparam int PW      = PRICE_BITS;
    localparam int SW_W    = (WEIGHT_FRAC_BITS + 1 > WGT_IN_W) ? WEIGHT_FRAC_BITS + 1 : WGT_IN_W;
    localparam int LOG_N   = $clog2(MAX_SLOTS + 1);
    localparam int CNT_W   = LOG_N;
    localparam int STEP_W  = (LOG_N > 3) ? LOG_N : 3;
    localparam int DATA_W  = PW + OI_W + VOL_W + TURN_W + TS_W + DATE_W;
    localparam int OI_LSB   = PW;
    localparam int VOL_LSB  = OI_LSB + OI_W;
    localparam int TURN_LSB = VOL_LSB + VOL_W;
    localparam int TS_LSB   = TURN_LSB + TURN_W;
    localparam int DATE_LSB = TS_LSB + TS_W;
    localparam int H       = PW / 2;
    localparam int HI_W    = PW - H;
    localparam int PFW     = PW + 32;
    localparam int K       = (PFW + 2) / 3;
    localparam int LAST_W  = PFW - 2 * K;
    localparam int TERM_W  = PFW + SW_W;
    localparam int NUM_W   = TERM_W + LOG_N;
    localparam int BASE_W  = 32 + LOG_N;
    localparam int WSUM_W  = SW_W + LOG_N;
    localparam logic [SW_W-1:0] WGT_ONE = SW_W'(1) << WEIGHT_FRAC_BITS;
    localparam logic [SUMV_W-1:0] SUMV_MAX = '1;
    localparam logic [SUMT_W-1:0] SUMT_MAX = '1;
    localparam logic [TS_W-1:0]   TS_MAX   = '1;

    logic [MODE_W-1:0]  r_cfg_mode;
    logic [SCALE_W-1:0] r_cfg_scale;
    logic               r_cfg_any;
    logic [SLOT_W-1:0]  r_cfg_tslot;
    logic [TOFF_W-1:0]  r_cfg_toff;
    logic [COUNT_W-1:0] r_cfg_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode  <= WM_FIXED;
            r_cfg_scale <= SCALE_ONE;
            r_cfg_any   <= 1'b1;
            r_cfg_tslot <= '0;
            r_cfg_toff  <= '0;
            r_cfg_count <= COUNT_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MODE:  r_cfg_mode  <= i_cfg_wdata[MODE_W-1:0];
                CFG_SCALE: r_cfg_scale <= i_cfg_wdata[SCALE_W-1:0];
                CFG_ANY:   r_cfg_any   <= i_cfg_wdata[0];
                CFG_TSLOT: r_cfg_tslot <= i_cfg_wdata[SLOT_W-1:0];
                CFG_TOFF:  r_cfg_toff  <= i_cfg_wdata[TOFF_W-1:0];
                CFG_COUNT: r_cfg_count <= i_cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] w_cnt;
    assign w_cnt = (32'(r_cfg_count) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(r_cfg_count);

    logic [SLOT_W-1:0]   w_slot;
    logic [PW-1:0]       w_in_price;
    logic [WGT_IN_W-1:0] w_in_wgt;
    logic [SW_W-1:0]     w_wr_weight;
    logic [DATA_W-1:0]   w_wr_data;
    logic                w_cmd;
    logic                w_s_acc;
    logic                w_in_use;
    logic                w_trig;

    assign w_slot      = s_axis_tdata[0 +: SLOT_W];
    assign w_in_price  = PW'(s_axis_tdata[6 +: PRICE_IN_W]);
    assign w_in_wgt    = s_axis_tdata[233 +: WGT_IN_W];
    assign w_wr_weight = (w_in_wgt == '0) ? WGT_ONE : SW_W'(w_in_wgt);
    assign w_wr_data   = {s_axis_tdata[206 +: DATE_W], s_axis_tdata[158 +: TS_W],
                          s_axis_tdata[110 +: TURN_W], s_axis_tdata[78 +: VOL_W],
                          s_axis_tdata[46 +: OI_W], w_in_price};
    assign w_cmd       = s_axis_tuser[0];
    assign w_s_acc     = s_axis_tvalid && s_axis_tready;
    assign w_in_use    = (32'(w_slot) < 32'(w_cnt));
    assign w_trig      = r_cfg_any || (w_slot == r_cfg_tslot);

    t_wic_state        r_state;
    t_wic_state        n_state;
    logic [STEP_W-1:0] r_step;
    t_cell_ctl         w_ctl;

    assign w_ctl.shift     = (r_state == S_WALK);
    assign w_ctl.we_quote  = w_s_acc && !w_cmd && w_in_use;
    assign w_ctl.we_weight = w_s_acc && w_cmd;
    assign w_ctl.slot      = w_slot;

    logic              w_valid  [MAX_SLOTS];
    logic [SW_W-1:0]   w_weight [MAX_SLOTS];
    logic [DATA_W-1:0] w_data   [MAX_SLOTS];

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        wic_cell #(
            .DATA_W   (DATA_W),
            .WGT_W    (SW_W),
            .WFB      (WEIGHT_FRAC_BITS),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_wr_weight  (w_wr_weight),
            .i_wr_data    (w_wr_data),
            .i_nbr_valid  (w_valid[(g + 1) % MAX_SLOTS]),
            .i_nbr_weight (w_weight[(g + 1) % MAX_SLOTS]),
            .i_nbr_data   (w_data[(g + 1) % MAX_SLOTS]),
            .o_valid      (w_valid[g]),
            .o_weight     (w_weight[g]),
            .o_data       (w_data[g])
        );
    end

    logic [PW-1:0]     h_price;
    logic [OI_W-1:0]   h_oi;
    logic [VOL_W-1:0]  h_vol;
    logic [TURN_W-1:0] h_turn;
    logic [TS_W-1:0]   h_ts;
    logic [DATE_W-1:0] h_date;
    logic [31:0]       w_f;
    logic              w_head_in;

    assign h_price   = w_data[0][0 +: PW];
    assign h_oi      = w_data[0][OI_LSB +: OI_W];
    assign h_vol     = w_data[0][VOL_LSB +: VOL_W];
    assign h_turn    = w_data[0][TURN_LSB +: TURN_W];
    assign h_ts      = w_data[0][TS_LSB +: TS_W];
    assign h_date    = w_data[0][DATE_LSB +: DATE_W];
    assign w_f       = (r_cfg_mode == WM_INTEREST) ? h_oi :
                       (r_cfg_mode == WM_VOLUME) ? h_vol : 32'd1;
    assign w_head_in = (r_state == S_WALK) && (32'(r_step) < 32'(w_cnt));

    logic                   r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic [H+31:0]          r_s1_lo;
    logic [HI_W+31:0]       r_s1_hi;
    logic [SW_W-1:0]        r_s1_w, r_s2_w;
    logic [PFW-1:0]         r_s2_pf;
    logic [K+SW_W-1:0]      r_s3_p0, r_s3_p1;
    logic [LAST_W+SW_W-1:0] r_s3_p2;
    logic [TERM_W-1:0]      r_s4_term;
    logic [NUM_W-1:0]       r_num;
    logic [WSUM_W-1:0]      r_wsum;
    logic [BASE_W-1:0]      r_base;
    logic [SUMV_W-1:0]      r_svol, r_soi;
    logic [SUMT_W-1:0]      r_sturn;
    logic [TS_W-1:0]        r_tmax;
    logic [DATE_W-1:0]      r_dmax;
    logic                   r_allv;
    logic [SUMV_W:0]        w_svol_add, w_soi_add;
    logic [SUMT_W:0]        w_sturn_add;

    assign w_svol_add  = {1'b0, r_svol} + (SUMV_W + 1)'(h_vol);
    assign w_soi_add   = {1'b0, r_soi} + (SUMV_W + 1)'(h_oi);
    assign w_sturn_add = {1'b0, r_sturn} + (SUMT_W + 1)'(h_turn);

    logic w_clear;
    assign w_clear = (r_state == S_IDLE) && w_ctl.we_quote && w_trig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s1_v <= w_head_in;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_lo   <= (H + 32)'(h_price[H-1:0]) * (H + 32)'(w_f);
        r_s1_hi   <= (HI_W + 32)'(h_price[PW-1:H]) * (HI_W + 32)'(w_f);
        r_s1_w    <= w_weight[0];
        r_s2_pf   <= PFW'(r_s1_lo) + (PFW'(r_s1_hi) << H);
        r_s2_w    <= r_s1_w;
        r_s3_p0   <= (K + SW_W)'(r_s2_pf[K-1:0]) * (K + SW_W)'(r_s2_w);
        r_s3_p1   <= (K + SW_W)'(r_s2_pf[2*K-1:K]) * (K + SW_W)'(r_s2_w);
        r_s3_p2   <= (LAST_W + SW_W)'(r_s2_pf[PFW-1:2*K]) * (LAST_W + SW_W)'(r_s2_w);
        r_s4_term <= TERM_W'(r_s3_p0) + (TERM_W'(r_s3_p1) << K)
                   + (TERM_W'(r_s3_p2) << (2 * K));
        if (w_clear) begin
            r_num   <= '0;
            r_wsum  <= '0;
            r_base  <= '0;
            r_svol  <= '0;
            r_soi   <= '0;
            r_sturn <= '0;
            r_tmax  <= '0;
            r_dmax  <= '0;
            r_allv  <= 1'b1;
        end else begin
            if (r_s4_v) r_num <= r_num + NUM_W'(r_s4_term);
            if (w_head_in) begin
                r_allv  <= r_allv & w_valid[0];
                r_wsum  <= r_wsum + WSUM_W'(w_weight[0]);
                if (r_cfg_mode == WM_INTEREST || r_cfg_mode == WM_VOLUME) begin
                    r_base <= r_base + BASE_W'(w_f);
                end
                r_svol  <= w_svol_add[SUMV_W] ? SUMV_MAX : w_svol_add[SUMV_W-1:0];
                r_soi   <= w_soi_add[SUMV_W] ? SUMV_MAX : w_soi_add[SUMV_W-1:0];
                r_sturn <= w_sturn_add[SUMT_W] ? SUMT_MAX : w_sturn_add[SUMT_W-1:0];
                if (h_ts > r_tmax) r_tmax <= h_ts;
                if (h_date > r_dmax) r_dmax <= h_date;
            end
        end
    end

    logic [BASE_W-1:0]  w_base_eff;
    logic [SCALE_W-1:0] w_scale_eff;
    logic               w_err;
    logic               w_drain_end;
    logic               w_div_start;
    logic               w_div_done;
    logic [PW-1:0]      w_div_quot;
    logic               w_out_free;

    assign w_base_eff  = (r_cfg_mode == WM_FIXED) ? BASE_W'(1) : r_base;
    assign w_scale_eff = (r_cfg_scale == '0) ? SCALE_ONE : r_cfg_scale;
    assign w_err       = (r_cfg_mode == WM_BAD) || (w_base_eff == '0);
    assign w_drain_end = (r_state == S_DRAIN) && (r_step == STEP_W'(PIPE_LAST));
    assign w_div_start = w_drain_end && r_allv && !w_err;
    assign w_out_free  = !m_axis_tvalid || m_axis_tready;

    wic_div #(
        .NUM_W  (NUM_W),
        .BASE_W (BASE_W),
        .WSUM_W (WSUM_W),
        .PW     (PW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_scale (w_scale_eff),
        .i_base  (w_base_eff),
        .i_wsum  (r_wsum),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_clear) n_state = S_WALK;
            end
            S_WALK: begin
                if (r_step == STEP_W'(MAX_SLOTS - 1)) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (w_drain_end) begin
                    priority if (!r_allv) n_state = S_IDLE;
                    else if (w_err)       n_state = S_DONE;
                    else                  n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);

    logic              r_err;
    logic [PW-1:0]     r_quot;
    logic              r_started;
    logic [PW-1:0]     r_open, r_high, r_low;
    logic [DATE_W-1:0] r_fdate;
    logic [PW-1:0]     n_open, n_high, n_low;
    logic [DATE_W-1:0] n_fdate;
    logic [PW-1:0]     w_index;
    logic [TS_W:0]     w_time_add;
    logic [TS_W-1:0]   w_time;

    assign w_index    = r_err ? '0 : r_quot;
    assign w_time_add = {1'b0, r_tmax} + (TS_W + 1)'(r_cfg_toff);
    assign w_time     = w_time_add[TS_W] ? TS_MAX : w_time_add[TS_W-1:0];

    always_comb begin
        n_open  = r_open;
        n_high  = r_high;
        n_low   = r_low;
        n_fdate = r_fdate;
        if (!r_err) begin
            if (!r_started) begin
                n_open  = r_quot;
                n_high  = r_quot;
                n_low   = r_quot;
                n_fdate = r_dmax;
            end else begin
                if (r_quot > r_high) n_high = r_quot;
                if (r_quot < r_low)  n_low  = r_quot;
            end
        end
    end

    logic w_load_out;
    assign w_load_out = (r_state == S_DONE) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step        <= '0;
            r_started     <= 1'b0;
            r_open        <= '0;
            r_high        <= '0;
            r_low         <= '0;
            r_fdate       <= '0;
            r_err         <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_WALK: begin
                    r_step <= (r_step == STEP_W'(MAX_SLOTS - 1)) ? '0 : r_step + 1'b1;
                end
                S_DRAIN: begin
                    r_step <= w_drain_end ? '0 : r_step + 1'b1;
                    if (w_drain_end) r_err <= w_err;
                end
                default: r_step <= '0;
            endcase
            if (w_div_done) r_quot <= w_div_quot;
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            if (w_load_out) begin
                m_axis_tvalid <= 1'b1;
                m_axis_tdata  <= {3'b000, r_fdate == n_fdate ? n_fdate : n_fdate, w_time,
                                  r_sturn, r_soi, r_svol,
                                  OUT_VAL_W'(n_low), OUT_VAL_W'(n_high),
                                  OUT_VAL_W'(n_open), OUT_VAL_W'(w_index)};
                m_axis_tuser  <= r_err;
                r_open        <= n_open;
                r_high        <= n_high;
                r_low         <= n_low;
                r_fdate       <= n_fdate;
                if (!r_err) r_started <= 1'b1;
            end
        end
    end

endmodule

>>> sv/wic_checker.sv
`timescale 1ns / 1ps
module wic_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [wic_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [0:0]                      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [wic_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                      m_axis_tuser,
    input logic                            i_cfg_we,
    input logic [wic_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input logic [wic_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import wic_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("Output transaction changed while stalled.");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[OUT_VAL_W-1:0] == '0)
        else $error("Divide error with a nonzero index value.");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> s_axis_tready)
        else $error("Weight load did not return to idle.");

    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("Result appeared one cycle after an input transaction.");

endmodule

bind weighted_index_calculator_core wic_checker u_wic_checker (.*);
